/* hdl/b64sd_pkg.sv */
// shared types, constants and character mapping for the base64 stream decoder
`default_nettype none

package b64sd_pkg;

  localparam logic [6:0] PAD_CODE = 7'h7F;
  localparam logic [7:0] BAD_CODE = 8'hFF;

  localparam logic [6:0] CH_CR     = 7'h0D;
  localparam logic [6:0] CH_LF     = 7'h0A;
  localparam logic [6:0] CH_PLUS   = 7'h2B;
  localparam logic [6:0] CH_SLASH  = 7'h2F;
  localparam logic [6:0] CH_MINUS  = 7'h2D;
  localparam logic [6:0] CH_UNDER  = 7'h5F;
  localparam logic [6:0] CH_EQUALS = 7'h3D;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_UPPER_Z = 7'h5A;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_LOWER_Z = 7'h7A;
  localparam logic [6:0] CH_DIGIT_0 = 7'h30;
  localparam logic [6:0] CH_DIGIT_9 = 7'h39;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_PAD  = 2'd2;
  localparam logic [1:0] ST_LONE     = 2'd3;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_data;
    logic [1:0] status;
    logic       last;
  } b64sd_res_t;

  // 6-bit code, pad code, or bad code for a 7-bit character
  function automatic logic [7:0] char_to_code(input logic [6:0] c, input logic url);
    logic [7:0] code;
    code = BAD_CODE;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      code = {1'b0, c - CH_UPPER_A};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      code = {1'b0, c - CH_LOWER_A + 7'd26};
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      code = {1'b0, c - CH_DIGIT_0 + 7'd52};
    end else if (c == CH_EQUALS) begin
      code = {1'b0, PAD_CODE};
    end else if (url) begin
      if (c == CH_MINUS) code = 8'd62;
      else if (c == CH_UNDER) code = 8'd63;
    end else begin
      if (c == CH_PLUS) code = 8'd62;
      else if (c == CH_SLASH) code = 8'd63;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* hdl/base64_stream_decoder.sv */
// top level of the base64 stream decoder: character decode and result queue
`default_nettype none

// Streaming base64 decoder, standard or url-safe alphabet.
// input channel: one character beat (in_char, in_end_of_string) per cycle,
//   accepted when in_valid is high and in_stall is low
// output channel: one result beat per cycle while out_stall is low, a data byte (out_is_data=1) or
//   the status that closes a string (out_is_data=0, out_last=1)
// cfg port: cfg_wr_en writes cfg_wr_data into url_r; write only when idle
// queueing: a character's results are written into the result queue registers
//   when it is accepted and leave from the queue head in order
// throughput: one character per cycle; a character makes up to four results
//   (three bytes and a status), drained one per cycle while out_stall is low
//   from an eight-entry result queue, so in_stall rises below four free entries
// the decode itself (group state update and byte packing) is combinational
//   logic between the input handshake and the queue registers
// reset: group count, drop flag, queue pointers and mode clear; held codes
//   need no reset since only codes written earlier in the group are read
// receiver stall: the queue holds its beats, fills, and then stalls the sender
module base64_stream_decoder
  import b64sd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_is_data,
  output logic [1:0]      out_status,
  output logic            out_last
);

  localparam int QDepth = 8;
  localparam int QAw    = $clog2(QDepth);
  localparam int MaxRes = 4;

  // mode and group state
  logic            url_r;
  logic [6:0]      store_r [4];
  logic [1:0]      cnt_r, cnt_nxt;
  logic            drop_r, drop_nxt;

  // result queue
  b64sd_res_t      q_r [QDepth];
  logic [QAw-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QAw:0]    q_cnt_r;

  logic            in_fire, out_fire;
  logic [7:0]      code;
  logic            skip, bad, store_en, full_grp;
  logic [6:0]      cur [4];
  logic [2:0]      n_left;
  logic [1:0]      st;
  logic [23:0]     packed_bits;
  logic [1:0]      nbytes;
  b64sd_res_t      res [MaxRes];
  logic [2:0]      nres;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (q_cnt_r > (QAw+1)'(QDepth - MaxRes));

  assign code     = char_to_code(in_char[6:0], url_r);
  // high bytes and line breaks are simply skipped
  assign skip     = in_char[7] || (in_char[6:0] == CH_CR) || (in_char[6:0] == CH_LF);
  assign bad      = !skip && (code == BAD_CODE);
  assign store_en = !drop_r && !skip && !bad;
  assign full_grp = store_en && (cnt_r == 2'd3);

  // group as it stands with this character's code placed in its slot
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cur[i] = (store_en && cnt_r == 2'(i)) ? code[6:0] : store_r[i];
    end
  end

  // codes held after this character, counting a full group as four
  assign n_left = {1'b0, cnt_r} + {2'b0, store_en};

  always_comb begin
    logic [2:0] n;
    n           = 3'd0;
    st          = ST_OK;
    if (bad) begin
      st = ST_BAD_CHAR;
    end else if (full_grp) begin
      n = 3'd4;
      if (cur[0] == PAD_CODE || cur[1] == PAD_CODE) begin
        st = ST_BAD_PAD;
      end else if (cur[2] == PAD_CODE) begin
        if (cur[3] != PAD_CODE) st = ST_BAD_PAD;
        else n = 3'd2;
      end else if (cur[3] == PAD_CODE) begin
        n = 3'd3;
      end
    end else if (!drop_r && in_end_of_string && n_left != 3'd0) begin
      // short leftover group, no pad checks
      n = n_left;
      if (n == 3'd1) st = ST_LONE;
    end
    unique case (n)
      3'd2: begin
        packed_bits = {16'b0, cur[0][5:0], 2'b0} | {21'b0, cur[1][6:4]};
        nbytes      = 2'd1;
      end
      3'd3: begin
        packed_bits = {7'b0, cur[0], 10'b0} | {13'b0, cur[1], 4'b0}
                    | {19'b0, cur[2][6:2]};
        nbytes      = 2'd2;
      end
      3'd4: begin
        packed_bits = {cur[0][5:0], 18'b0} | {5'b0, cur[1], 12'b0}
                    | {11'b0, cur[2], 6'b0} | {17'b0, cur[3]};
        nbytes      = 2'd3;
      end
      default: begin
        packed_bits = '0;
        nbytes      = 2'd0;
      end
    endcase
  end

  // result list for this beat: bytes high first, then the closing status
  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '{byte_val: 8'h00, is_data: 1'b0, status: ST_OK, last: 1'b1};
    end
    nres = 3'd0;
    if (!drop_r) begin
      if (st != ST_OK) begin
        res[0].status = st;
        nres          = 3'd1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < nbytes) begin
            res[i].byte_val = packed_bits[8*(nbytes - 2'(i)) - 1 -: 8];
            res[i].is_data  = 1'b1;
            res[i].last     = 1'b0;
          end
        end
        nres = {1'b0, nbytes} + {2'b0, in_end_of_string};
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (drop_r) begin
      if (in_end_of_string) begin
        drop_nxt = 1'b0;
        cnt_nxt  = 2'd0;
      end
    end else if (st != ST_OK) begin
      cnt_nxt  = 2'd0;
      drop_nxt = !in_end_of_string;
    end else if (in_end_of_string || full_grp) begin
      cnt_nxt = 2'd0;
    end else if (store_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r    <= 1'b0;
      cnt_r    <= 2'd0;
      drop_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) url_r <= cfg_wr_data;
      if (in_fire) begin
        cnt_r    <= cnt_nxt;
        drop_r   <= drop_nxt;
        wr_ptr_r <= wr_ptr_r + QAw'(in_fire ? nres : 3'd0);
      end
      if (out_fire) rd_ptr_r <= rd_ptr_r + QAw'(1);
      q_cnt_r <= q_cnt_r + (QAw+1)'(in_fire ? nres : 3'd0) - (QAw+1)'(out_fire);
    end
  end

  // held codes and queue payload
  always_ff @(posedge clk) begin
    if (in_fire && store_en) store_r[cnt_r] <= code[6:0];
    if (in_fire) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (3'(i) < nres) q_r[QAw'(wr_ptr_r + QAw'(i))] <= res[i];
      end
    end
  end

  assign out_valid   = (q_cnt_r != '0);
  assign out_byte    = q_r[rd_ptr_r].byte_val;
  assign out_is_data = q_r[rd_ptr_r].is_data;
  assign out_status  = q_r[rd_ptr_r].status;
  assign out_last    = q_r[rd_ptr_r].last;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (QAw+1)'(QDepth))
    else $error("result queue overflow");

  a_drop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_string) |=> (!drop_r && cnt_r == 2'd0))
    else $error("string end left group state behind");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_data) |-> (out_status == ST_OK && !out_last))
    else $error("data beat with status or last");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_data) |-> (out_last && out_byte == 8'h00))
    else $error("status beat not closing a string");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking testbench for the base64 stream decoder: directed strings and random streams
`timescale 1ns / 100ps

module testbench;
  import b64sd_pkg::*;

  // generous ceiling: ~470 characters, up to four beats each, random stalls on both sides
  localparam int CYCLE_LIMIT = 200000;
  // cycles to let the decode settle before a config write or the end
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic [1:0] out_status;
  logic       out_last;

  // no idling on either side while set
  logic calm = 1'b0;

  int cycles = 0;
  int mismatches = 0;
  int chars_sent = 0;

  // decoder state as the bench sees it
  logic       url_mode = 1'b0;
  logic [6:0] grp [4] = '{7'd0, 7'd0, 7'd0, 7'd0};
  logic [1:0] grp_cnt = 2'd0;
  logic       dropping = 1'b0;

  // beats still owed by the decoder, oldest first
  b64sd_res_t owed_beats[$];

  base64_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char          (in_char),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_is_data      (out_is_data),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall: about a quarter of the cycles, none while calm
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 24);
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // 6-bit value of a character, pad code for '=', bad code for anything else
  function automatic logic [7:0] code_of(input logic [7:0] ch, input logic url);
    logic [6:0] c;
    c = ch[6:0];
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return {1'b0, c - CH_UPPER_A};
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return {1'b0, c - CH_LOWER_A + 7'd26};
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return {1'b0, c - CH_DIGIT_0 + 7'd52};
    if (c == CH_EQUALS) return {1'b0, PAD_CODE};
    if (c == (url ? CH_MINUS : CH_PLUS)) return 8'd62;
    if (c == (url ? CH_UNDER : CH_SLASH)) return 8'd63;
    return BAD_CODE;
  endfunction

  // turn the held codes into data beats; pad rules apply only to a full group
  function automatic logic [1:0] unpack_group(input int n, input logic check_pad);
    logic [31:0] c0, c1, c2, c3, packed_bits;
    int nbytes;
    c0 = grp[0];
    c1 = grp[1];
    c2 = grp[2];
    c3 = grp[3];
    if (n == 1) return ST_LONE;
    if (n == 4 && check_pad) begin
      if (c0 == PAD_CODE || c1 == PAD_CODE) return ST_BAD_PAD;
      if (c2 == PAD_CODE) begin
        if (c3 != PAD_CODE) return ST_BAD_PAD;
        n = 2;
      end else if (c3 == PAD_CODE) begin
        n = 3;
      end
    end
    case (n)
      2: begin
        packed_bits = (c0 << 2) | (c1 >> 4);
        nbytes = 1;
      end
      3: begin
        packed_bits = (c0 << 10) | (c1 << 4) | (c2 >> 2);
        nbytes = 2;
      end
      default: begin
        packed_bits = (c0 << 18) | (c1 << 12) | (c2 << 6) | c3;
        nbytes = 3;
      end
    endcase
    // most significant byte goes out first
    for (int b = nbytes - 1; b >= 0; b--)
      owed_beats.push_back(b64sd_res_t'{packed_bits[8*b +: 8], 1'b1, ST_OK, 1'b0});
    return ST_OK;
  endfunction

  // advance the bench state by one accepted character and queue its beats
  function automatic void decode_char(input logic [7:0] ch, input logic eos);
    logic [7:0] code;
    logic [1:0] st;
    st = ST_OK;
    // rest of a failed string: silent, the end flag rearms
    if (dropping) begin
      if (eos) begin
        dropping = 1'b0;
        grp_cnt = 2'd0;
      end
      return;
    end
    // high bytes and line breaks are skipped but may still carry the end flag
    if (!ch[7] && ch[6:0] != CH_CR && ch[6:0] != CH_LF) begin
      code = code_of(ch, url_mode);
      if (code == BAD_CODE) begin
        st = ST_BAD_CHAR;
      end else begin
        grp[grp_cnt] = code[6:0];
        if (grp_cnt == 2'd3) begin
          grp_cnt = 2'd0;
          st = unpack_group(4, 1'b1);
        end else begin
          grp_cnt++;
        end
      end
    end
    // leftover group at the end decodes without pad checks
    if (st == ST_OK && eos && grp_cnt != 2'd0) begin
      st = unpack_group(grp_cnt, 1'b0);
      grp_cnt = 2'd0;
    end
    // first error closes the string at once
    if (st != ST_OK) begin
      owed_beats.push_back(b64sd_res_t'{8'h00, 1'b0, st, 1'b1});
      grp_cnt = 2'd0;
      dropping = !eos;
      return;
    end
    if (eos) begin
      grp_cnt = 2'd0;
      owed_beats.push_back(b64sd_res_t'{8'h00, 1'b0, ST_OK, 1'b1});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking, oldest expectation first
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    b64sd_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected beat: byte=%h data=%b status=%0d last=%b",
                   out_byte, out_is_data, out_status, out_last);
      end else begin
        want = owed_beats.pop_front();
        if (out_byte !== want.byte_val || out_is_data !== want.is_data ||
            out_status !== want.status || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch at cycle %0d: want %h/%b/%0d/%b got %h/%b/%0d/%b",
                     cycles, want.byte_val, want.is_data, want.status, want.last,
                     out_byte, out_is_data, out_status, out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one character beat; random idle cycles in front unless calm
  task automatic send_char(input logic [7:0] ch, input logic eos);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 24);
    end
    in_valid <= 1'b1;
    in_char <= ch;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    decode_char(ch, eos);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], close && (i == s.len() - 1));
  endtask

  // sender holds off until every owed beat is out, then lets the decode settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mode writes only with the decoder idle and no string open
  task automatic set_url_mode(input logic mode);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    url_mode = mode;
  endtask

  function automatic logic [7:0] code_char(input int code, input logic url);
    if (code < 26) return {1'b0, CH_UPPER_A} + 8'(code);
    if (code < 52) return {1'b0, CH_LOWER_A} + 8'(code - 26);
    if (code < 62) return {1'b0, CH_DIGIT_0} + 8'(code - 52);
    if (code == 62) return {1'b0, url ? CH_MINUS : CH_PLUS};
    return {1'b0, url ? CH_UNDER : CH_SLASH};
  endfunction

  // characters the decoder skips: line breaks and high bytes
  function automatic logic [7:0] filler_char();
    case ($urandom_range(2))
      0: return {1'b0, CH_CR};
      1: return {1'b0, CH_LF};
      default: return 8'h80 | 8'($urandom_range(127));
    endcase
  endfunction

  // the two symbols of the other alphabet
  function automatic logic [7:0] foreign_char(input logic url);
    if (url) return {1'b0, $urandom_range(1) ? CH_PLUS : CH_SLASH};
    return {1'b0, $urandom_range(1) ? CH_MINUS : CH_UNDER};
  endfunction

  function automatic logic [7:0] noise_char(input logic url);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 8'($urandom_range(255));
      5, 6, 7: return code_char($urandom_range(63), url);
      8: return {1'b0, CH_EQUALS};
      default: return $urandom_range(1) ? foreign_char(url) : filler_char();
    endcase
  endfunction

  // one encoded string of up to four groups, optionally with one fault
  task automatic send_encoded(input logic corrupt);
    logic [7:0] text[$];
    int groups, tail, pos;
    groups = $urandom_range(3);
    tail = $urandom_range(4);
    if (groups == 0 && tail == 0) tail = 1 + $urandom_range(3);
    repeat (groups * 4) text.push_back(code_char($urandom_range(63), url_mode));
    // tail: two codes with two pads, three codes with one pad, or a short group
    case (tail)
      1: begin
        repeat (2) text.push_back(code_char($urandom_range(63), url_mode));
        repeat (2) text.push_back({1'b0, CH_EQUALS});
      end
      2: begin
        repeat (3) text.push_back(code_char($urandom_range(63), url_mode));
        text.push_back({1'b0, CH_EQUALS});
      end
      3: repeat (2) text.push_back(code_char($urandom_range(63), url_mode));
      4: repeat (3) text.push_back(code_char($urandom_range(63), url_mode));
      default: ;
    endcase
    if (corrupt) begin
      pos = $urandom_range(text.size() - 1);
      case ($urandom_range(3))
        0: text[pos] = {1'b0, CH_EQUALS};
        1: text[pos] = foreign_char(url_mode);
        2: text[pos] = 8'($urandom_range(127));
        default: if (text.size() > 1) text.delete(pos);
      endcase
    end
    // sprinkle skipped characters, sometimes one carries the end flag
    for (int i = text.size() - 1; i >= 0; i--)
      if ($urandom_range(99) < 8) text.insert(i, filler_char());
    if ($urandom_range(99) < 15) text.push_back(filler_char());
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // standard alphabet: symbols, pads, bad pad, lone code, skips, drop on error
  task automatic test_standard_vectors();
    send_text("+/", 1'b0);
    send_char({1'b0, CH_CR}, 1'b0);
    send_text("9z", 1'b1);
    send_text("A=", 1'b1);
    send_text("TQ==", 1'b1);
    send_text("AA=A", 1'b1);
    send_text("Q", 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("-", 1'b0);
    send_char({1'b0, CH_LF}, 1'b1);
  endtask

  // url-safe alphabet: its own symbols, a foreign one on the last character,
  // pad inside a short group
  task automatic test_url_vectors();
    send_text("-_", 1'b1);
    send_text("+", 1'b1);
    send_text("AB=", 1'b1);
  endtask

  task automatic test_wellformed_strings(input int budget);
    int stop_at;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) send_encoded(1'b0);
  endtask

  // mostly well-formed strings with one fault each, some clean
  task automatic test_corrupted_strings(input int budget);
    int stop_at;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) send_encoded($urandom_range(99) < 70);
  endtask

  task automatic test_noise_strings(input int budget);
    int stop_at, len;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      len = 1 + $urandom_range(9);
      for (int i = 0; i < len; i++) send_char(noise_char(url_mode), i == len - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_url_mode(1'b0);
    test_standard_vectors();
    set_url_mode(1'b1);
    test_url_vectors();

    // long burst with both sides running flat out
    calm = 1'b1;
    test_wellformed_strings(90);
    calm = 1'b0;
    test_wellformed_strings(30);

    set_url_mode(1'b0);
    test_wellformed_strings(80);
    test_corrupted_strings(60);
    // sender holds off mid-phase until everything is out
    wait_drained();
    test_noise_strings(35);

    set_url_mode(1'b1);
    test_corrupted_strings(55);
    test_noise_strings(35);

    set_url_mode(1'b0);
    test_noise_strings(30);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
